// ----- sv/spatial_vector_transform_unit_defines.svh -----
// assertion macros for the spatial vector transform unit
`ifndef SPATIAL_VECTOR_TRANSFORM_UNIT_DEFINES_SVH
`define SPATIAL_VECTOR_TRANSFORM_UNIT_DEFINES_SVH

// condition must hold at every clock while out of reset
`define SVT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/svt_pkg.sv -----
// types, constants and helpers of the spatial vector transform unit
package svt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int ROT_W = 18;
    localparam int ROW_W = 3 * ROT_W;
    localparam int PROD_W = ROT_W + DATA_W;
    localparam int CROSS_W = 2 * DATA_W;
    localparam int ACC_W = 68;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 3'd5;

    localparam logic [ROW_W-1:0] ROW0_RESET = 54'd65536;
    localparam logic [ROW_W-1:0] ROW1_RESET = 54'd17179869184;
    localparam logic [ROW_W-1:0] ROW2_RESET = 54'd4503599627370496;

    localparam logic signed [ACC_W-1:0] SAT_HI = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 68'sd1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ROT_W-1:0] rot_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [1:0] op_t;

    typedef struct packed {
        op_t   op;
        data_t ang_x;
        data_t ang_y;
        data_t ang_z;
        data_t lin_x;
        data_t lin_y;
        data_t lin_z;
    } in_word_t;

    typedef struct packed {
        data_t out_ang_x;
        data_t out_ang_y;
        data_t out_ang_z;
        data_t out_lin_x;
        data_t out_lin_y;
        data_t out_lin_z;
    } out_word_t;

    // drop fraction bits (floor) and clamp to the data range
    function automatic data_t finish(input acc_t a);
        acc_t s;
        data_t r;
        s = a >>> FRAC_BITS;
        if (s > SAT_HI)
        begin
            r = SAT_HI[DATA_W-1:0];
        end
        else if (s < SAT_LO)
        begin
            r = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/svt_matvec.sv -----
// two-stage 3x3 matrix by vector product: products, then row sums
module svt_matvec (
    input  logic           clk,
    input  logic           en_prod,
    input  logic           en_sum,
    input  svt_pkg::rot_t  m [3][3],
    input  svt_pkg::data_t x [3],
    output svt_pkg::acc_t  sum [3]
);
    import svt_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [3][3];
    acc_t sum_reg [3];

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= PROD_W'(m[i][j]) * PROD_W'(x[j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= ACC_W'(prod_reg[i][0]) + ACC_W'(prod_reg[i][1])
                              + ACC_W'(prod_reg[i][2]);
            end
        end
    end

    assign sum = sum_reg;

endmodule

// ----- sv/spatial_vector_transform_unit.sv -----
// top level of the spatial vector transform unit
// Usage:
//   in_word/in_valid/in_ready carries op plus angular and linear triples.
//   out_word/out_valid/out_ready carries the transformed six-vector.
//   A word moves when valid and ready are both high at a rising edge.
//   cfg_wr_en/cfg_index/cfg_wdata writes rotation rows 0..2 (indexes 0..2)
//   and translation x, y, z (indexes 3..5); write only while idle.
// Throughput: one word per cycle while the receiver keeps out_ready high;
//   the pipeline holds the products, the first sums and clamp, the second
//   products, the second sums and the final clamp.
// Each stage advances when its successor is empty or advancing, so a
//   stalled receiver fills the pipeline up to six words before in_ready
//   drops; no word is lost or repeated.
// Reset clears all valid bits; rotation resets to identity and
//   translation to zero.
`include "spatial_vector_transform_unit_defines.svh"
module spatial_vector_transform_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  svt_pkg::in_word_t                 in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output svt_pkg::out_word_t                out_word,
    input  logic                              cfg_wr_en,
    input  logic [svt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [svt_pkg::ROW_W-1:0]         cfg_wdata
);
    import svt_pkg::*;

    logic [ROW_W-1:0] rot_row_reg [3];
    data_t trans_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0] <= ROW0_RESET;
            rot_row_reg[1] <= ROW1_RESET;
            rot_row_reg[2] <= ROW2_RESET;
            trans_reg[0] <= '0;
            trans_reg[1] <= '0;
            trans_reg[2] <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROT_ROW0: rot_row_reg[0] <= cfg_wdata;
                REG_ROT_ROW1: rot_row_reg[1] <= cfg_wdata;
                REG_ROT_ROW2: rot_row_reg[2] <= cfg_wdata;
                REG_TRANS_X:  trans_reg[0] <= cfg_wdata[DATA_W-1:0];
                REG_TRANS_Y:  trans_reg[1] <= cfg_wdata[DATA_W-1:0];
                REG_TRANS_Z:  trans_reg[2] <= cfg_wdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    rot_t r [3][3];
    rot_t rt [3][3];
    rot_t m_in [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r[i][j] = rot_t'(rot_row_reg[i][ROT_W*j +: ROT_W]);
                rt[j][i] = rot_t'(rot_row_reg[i][ROT_W*j +: ROT_W]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_in[i][j] = in_word.op[1] ? rt[i][j] : r[i][j];
            end
        end
    end

    // valid bits and handshake chain
    logic [6:1] v_reg;
    logic [7:1] rdy;
    logic [6:1] en;

    always_comb
    begin
        rdy[7] = out_ready;
        for (int k = 6; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        en = rdy[6:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready = rdy[1];
    assign out_valid = v_reg[6];

    // input selection
    data_t p_in [3];
    data_t q_in [3];

    always_comb
    begin
        if (in_word.op[0])
        begin
            p_in = '{in_word.lin_x, in_word.lin_y, in_word.lin_z};
            q_in = '{in_word.ang_x, in_word.ang_y, in_word.ang_z};
        end
        else
        begin
            p_in = '{in_word.ang_x, in_word.ang_y, in_word.ang_z};
            q_in = '{in_word.lin_x, in_word.lin_y, in_word.lin_z};
        end
    end

    // stage 1: products
    op_t op1_reg, op2_reg, op3_reg, op4_reg, op5_reg, op6_reg;
    data_t q1_reg [3];
    logic signed [CROSS_W-1:0] ca1_reg [3];
    logic signed [CROSS_W-1:0] cb1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            op1_reg <= in_word.op;
            q1_reg <= q_in;
            for (int i = 0; i < 3; i++)
            begin
                ca1_reg[i] <= CROSS_W'(trans_reg[(i+1)%3]) * CROSS_W'(p_in[(i+2)%3]);
                cb1_reg[i] <= CROSS_W'(trans_reg[(i+2)%3]) * CROSS_W'(p_in[(i+1)%3]);
            end
        end
    end

    acc_t sum_a [3];
    acc_t sum_c [3];
    acc_t sum_b [3];

    svt_matvec u_mv_p (
        .clk     (clk),
        .en_prod (en[1]),
        .en_sum  (en[2]),
        .m       (m_in),
        .x       (p_in),
        .sum     (sum_a)
    );

    svt_matvec u_mv_q (
        .clk     (clk),
        .en_prod (en[1]),
        .en_sum  (en[2]),
        .m       (m_in),
        .x       (q_in),
        .sum     (sum_c)
    );

    // stage 2: sums, shifted vector for the forward ops
    acc_t d2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            op2_reg <= op1_reg;
            for (int i = 0; i < 3; i++)
            begin
                d2_reg[i] <= (ACC_W'(q1_reg[i]) <<< FRAC_BITS)
                             - (ACC_W'(ca1_reg[i]) - ACC_W'(cb1_reg[i]));
            end
        end
    end

    // stage 3: first clamp
    data_t pr3_reg [3];
    data_t d3_reg [3];
    acc_t sc3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            op3_reg <= op2_reg;
            for (int i = 0; i < 3; i++)
            begin
                pr3_reg[i] <= finish(sum_a[i]);
                d3_reg[i] <= finish(d2_reg[i]);
                sc3_reg[i] <= sum_c[i];
            end
        end
    end

    // stage 4: second products
    data_t pr4_reg [3];
    acc_t sc4_reg [3];
    logic signed [CROSS_W-1:0] ca4_reg [3];
    logic signed [CROSS_W-1:0] cb4_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            op4_reg <= op3_reg;
            pr4_reg <= pr3_reg;
            sc4_reg <= sc3_reg;
            for (int i = 0; i < 3; i++)
            begin
                ca4_reg[i] <= CROSS_W'(trans_reg[(i+1)%3]) * CROSS_W'(pr3_reg[(i+2)%3]);
                cb4_reg[i] <= CROSS_W'(trans_reg[(i+2)%3]) * CROSS_W'(pr3_reg[(i+1)%3]);
            end
        end
    end

    svt_matvec u_mv_d (
        .clk     (clk),
        .en_prod (en[4]),
        .en_sum  (en[5]),
        .m       (r),
        .x       (d3_reg),
        .sum     (sum_b)
    );

    // stage 5: second sums
    data_t pr5_reg [3];
    acc_t x5_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            op5_reg <= op4_reg;
            pr5_reg <= pr4_reg;
            for (int i = 0; i < 3; i++)
            begin
                x5_reg[i] <= sc4_reg[i] + (ACC_W'(ca4_reg[i]) - ACC_W'(cb4_reg[i]));
            end
        end
    end

    // stage 6: final clamp and output word
    data_t pr6_reg [3];
    data_t qr6_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            op6_reg <= op5_reg;
            pr6_reg <= pr5_reg;
            for (int i = 0; i < 3; i++)
            begin
                qr6_reg[i] <= finish(op5_reg[1] ? x5_reg[i] : sum_b[i]);
            end
        end
    end

    always_comb
    begin
        if (op6_reg[0])
        begin
            out_word = '{out_ang_x: qr6_reg[0], out_ang_y: qr6_reg[1],
                         out_ang_z: qr6_reg[2], out_lin_x: pr6_reg[0],
                         out_lin_y: pr6_reg[1], out_lin_z: pr6_reg[2]};
        end
        else
        begin
            out_word = '{out_ang_x: pr6_reg[0], out_ang_y: pr6_reg[1],
                         out_ang_z: pr6_reg[2], out_lin_x: qr6_reg[0],
                         out_lin_y: qr6_reg[1], out_lin_z: qr6_reg[2]};
        end
    end

    `SVT_ASSERT_ALWAYS(a_full_when_blocked, in_ready || ((&v_reg) && !out_ready), "in_ready low with a bubble in the pipeline")
    `SVT_ASSERT_NEXT(a_no_invented_word, !v_reg[5] && !(v_reg[6] && !out_ready), !v_reg[6], "output word without a source")
    `SVT_ASSERT_NEXT(a_stage3_holds, v_reg[3] && !en[4], v_reg[3] && $stable(op3_reg), "stalled stage lost its word")

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the spatial vector transform unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import svt_pkg::*;

    localparam op_t OP_MOTION = 2'd0;
    localparam op_t OP_FORCE = 2'd1;
    localparam op_t OP_INV_MOTION = 2'd2;
    localparam op_t OP_INV_FORCE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SETTINGS_USED = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef logic signed [127:0] wide_t;

    class transform_scoreboard;
        logic [ROW_W-1:0] rows[3];
        data_t trans[3];
        out_word_t pending[$];
        int mismatches;
        int words_checked;
        int ops_seen[4];

        function new();
            rows[0] = ROW0_RESET;
            rows[1] = ROW1_RESET;
            rows[2] = ROW2_RESET;
            foreach (trans[i])
                trans[i] = '0;
            mismatches = 0;
            words_checked = 0;
            foreach (ops_seen[i])
                ops_seen[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
            case (idx)
                REG_ROT_ROW0: rows[0] = val;
                REG_ROT_ROW1: rows[1] = val;
                REG_ROT_ROW2: rows[2] = val;
                REG_TRANS_X: trans[0] = val[DATA_W-1:0];
                REG_TRANS_Y: trans[1] = val[DATA_W-1:0];
                REG_TRANS_Z: trans[2] = val[DATA_W-1:0];
                default: ;
            endcase
        endfunction

        function wide_t rot(int i, int j, bit tr);
            rot_t e;
            e = tr ? rows[j][ROT_W*i +: ROT_W] : rows[i][ROT_W*j +: ROT_W];
            return wide_t'(e);
        endfunction

        function data_t clamp(wide_t a);
            wide_t s;
            s = a >>> FRAC_BITS;
            if (s > wide_t'(32'sh7FFF_FFFF))
                return 32'sh7FFF_FFFF;
            if (s < -wide_t'(32'sh7FFF_FFFF) - 1)
                return 32'sh8000_0000;
            return s[DATA_W-1:0];
        endfunction

        function wide_t cross_term(int i, data_t x[3]);
            int j;
            int k;
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            return wide_t'(trans[j]) * wide_t'(x[k]) - wide_t'(trans[k]) * wide_t'(x[j]);
        endfunction

        function out_word_t transform(in_word_t w);
            data_t p[3], q[3], pr[3], qr[3], d[3];
            wide_t acc[3];
            bit inv;
            bit lin_first;
            out_word_t r;
            inv = w.op[1];
            lin_first = w.op[0];
            if (lin_first)
            begin
                p = '{w.lin_x, w.lin_y, w.lin_z};
                q = '{w.ang_x, w.ang_y, w.ang_z};
            end
            else
            begin
                p = '{w.ang_x, w.ang_y, w.ang_z};
                q = '{w.lin_x, w.lin_y, w.lin_z};
            end
            for (int i = 0; i < 3; i++)
            begin
                acc[i] = '0;
                for (int j = 0; j < 3; j++)
                    acc[i] += rot(i, j, inv) * wide_t'(p[j]);
                pr[i] = clamp(acc[i]);
            end
            if (!inv)
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = clamp(wide_t'(q[i]) * (wide_t'(1) << FRAC_BITS) - cross_term(i, p));
                for (int i = 0; i < 3; i++)
                begin
                    acc[i] = '0;
                    for (int j = 0; j < 3; j++)
                        acc[i] += rot(i, j, 1'b0) * wide_t'(d[j]);
                    qr[i] = clamp(acc[i]);
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc[i] = cross_term(i, pr);
                    for (int j = 0; j < 3; j++)
                        acc[i] += rot(i, j, 1'b1) * wide_t'(q[j]);
                    qr[i] = clamp(acc[i]);
                end
            end
            if (lin_first)
                r = '{qr[0], qr[1], qr[2], pr[0], pr[1], pr[2]};
            else
                r = '{pr[0], pr[1], pr[2], qr[0], qr[1], qr[2]};
            return r;
        endfunction

        function void note_input(in_word_t w);
            pending.push_back(transform(w));
            ops_seen[w.op]++;
        endfunction

        function void check_output(out_word_t got);
            out_word_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", got);
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (got.out_ang_x !== want.out_ang_x || got.out_ang_y !== want.out_ang_y ||
                got.out_ang_z !== want.out_ang_z || got.out_lin_x !== want.out_lin_x ||
                got.out_lin_y !== want.out_lin_y || got.out_lin_z !== want.out_lin_z)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch word %0d: expected %h actual %h",
                             words_checked, want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_word;
    logic out_valid;
    logic out_ready;
    out_word_t out_word;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0] cfg_wdata;

    transform_scoreboard sb = new();
    bit calm = 1'b0;
    int hold_requests = 0;

    spatial_vector_transform_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    initial
    begin
        #(12ns * 400000);
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver side with random stalls and one long hold-off
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_output(out_word);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic send_word(in_word_t w);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [ROW_W-1:0] pack_row(rot_t e0, rot_t e1, rot_t e2);
        return {e2, e1, e0};
    endfunction

    function automatic data_t pick_data();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return $urandom();
        if (sel < 75)
            return $signed($urandom_range(2 * 1048576)) - 1048576;
        if (sel < 85)
            return 32'sh7FFF_FFFF;
        if (sel < 95)
            return 32'sh8000_0000;
        return '0;
    endfunction

    function automatic rot_t pick_rot();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return rot_t'($urandom());
        if (sel == 6)
            return 18'sh1FFFF;
        if (sel == 7)
            return 18'sh20000;
        return rot_t'($signed($urandom_range(131072)) - 65536);
    endfunction

    task automatic load_setting(int n);
        rot_t e[9];
        data_t t[3];
        case (n)
            0:
            begin
                e = '{18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF,
                      18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF};
                t = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
            end
            1:
            begin
                e = '{18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000,
                      18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000};
                t = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
            end
            2:
            begin
                // quarter turn about z with a modest offset
                e = '{18'sh0, -18'sh10000, 18'sh0, 18'sh10000, 18'sh0,
                      18'sh0, 18'sh0, 18'sh0, 18'sh10000};
                t = '{32'sh0002_8000, -32'sh0001_0000, 32'sh0000_4000};
            end
            default:
            begin
                foreach (e[i])
                    e[i] = pick_rot();
                foreach (t[i])
                    t[i] = pick_data();
            end
        endcase
        write_reg(REG_ROT_ROW0, pack_row(e[0], e[1], e[2]));
        write_reg(REG_ROT_ROW1, pack_row(e[3], e[4], e[5]));
        write_reg(REG_ROT_ROW2, pack_row(e[6], e[7], e[8]));
        // stray upper bits on the translation writes
        write_reg(REG_TRANS_X, {22'($urandom_range(4194303)), t[0]});
        write_reg(REG_TRANS_Y, {22'($urandom_range(4194303)), t[1]});
        write_reg(REG_TRANS_Z, {22'($urandom_range(4194303)), t[2]});
        write_reg(REG_SPARE_A, ROW_W'({$urandom(), $urandom()}));
        write_reg(REG_SPARE_B, ROW_W'({$urandom(), $urandom()}));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_directed();
        data_t v[4];
        v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0001_0000};
        for (int o = 0; o < 4; o++)
            for (int k = 0; k < 4; k++)
                send_word('{op_t'(o), v[k], v[k], v[k], v[(k+1)%4], v[(k+1)%4], v[(k+1)%4]});
        send_word('{OP_MOTION, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1, 32'shFFFF_FFFF,
                    32'sh0, 32'sh7FFF_FFFF});
        send_word('{OP_INV_FORCE, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 32'sh1,
                    32'sh8000_0000, 32'sh0});
    endtask

    initial
    begin
        in_word_t w;
        int per_phase;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_word <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        per_phase = RANDOM_ITEMS / SETTINGS_USED;
        for (int s = 0; s < SETTINGS_USED; s++)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            drain();
            load_setting(s);
            if (s == 0)
                send_directed();
            if (s == 2)
                hold_requests++;
            calm = (s == 3);
            for (int n = 0; n < per_phase; n++)
            begin
                w.op = op_t'($urandom_range(3));
                w.ang_x = pick_data();
                w.ang_y = pick_data();
                w.ang_z = pick_data();
                w.lin_x = pick_data();
                w.lin_y = pick_data();
                w.lin_z = pick_data();
                send_word(w);
            end
            calm = 1'b0;
        end
        in_valid <= 1'b0;
        @(posedge clk);
        drain();

        $display("covered %0d words (motion %0d, force %0d, inverse motion %0d, inverse force %0d)",
                 sb.words_checked, sb.ops_seen[0], sb.ops_seen[1], sb.ops_seen[2],
                 sb.ops_seen[3]);
        $display("across %0d rotation and translation settings plus reset values, %0d mismatches",
                 SETTINGS_USED, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
